/* rtl/core/cor_pkg.sv */
// ----------------------------------------------------------------------------
// cor_pkg
// Shared types, codes and helpers of the circle outline rasterizer.
// ----------------------------------------------------------------------------
package cor_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int REG_W          = 16;
  localparam int RADIUS_W       = 14;
  localparam int COLOR_W        = 16;

  // Request codes on in_req_type.
  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  // One run of pixels handed from the step unit to the pixel emitter.
  typedef struct packed {
    logic [REG_W-1:0]   cx;
    logic [REG_W-1:0]   cy;
    logic [REG_W-1:0]   oc;
    logic [REG_W-1:0]   orw;
    logic [COLOR_W-1:0] color;
    logic               is_adv;
    logic               done;
  } cor_run_t;

  // Maps a pixel number within a run to a symmetry slot. Slot bit 2 swaps
  // the offsets, bit 1 negates the row term and bit 0 the column term.
  // A start run uses the slots whose column offset is zero.
  function automatic logic [2:0] pix_slot(input logic is_adv, input logic [2:0] idx);
    logic [2:0] slot;
    if (is_adv) begin
      slot = idx;
    end else begin
      case (idx[1:0])
        2'd0:    slot = 3'd0;
        2'd1:    slot = 3'd2;
        2'd2:    slot = 3'd4;
        default: slot = 3'd7;
      endcase
    end
    return slot;
  endfunction

endpackage

/* rtl/core/cor_step.sv */
// ----------------------------------------------------------------------------
// cor_step
// Input register and midpoint iteration: holds the circle state and turns
// each start, and each advance while a circle runs, into one run of pixels for the emitter.
// ----------------------------------------------------------------------------
module cor_step
  import cor_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_req_type,
  input  logic [REG_W-1:0]    in_center_x,
  input  logic [REG_W-1:0]    in_center_y,
  input  logic [RADIUS_W-1:0] in_radius,
  input  logic [COLOR_W-1:0]  in_pixel_color,
  output logic                run_valid,
  input  logic                run_ready,
  output cor_run_t            run
);

  logic                inq_vld_r, inq_vld_nxt;
  logic                inq_type_r;
  logic [REG_W-1:0]    inq_cx_r;
  logic [REG_W-1:0]    inq_cy_r;
  logic [RADIUS_W-1:0] inq_rad_r;
  logic [COLOR_W-1:0]  inq_color_r;

  logic [REG_W-1:0]   dec_r, dec_nxt;
  logic [REG_W-1:0]   sc_r, sc_nxt;
  logic [REG_W-1:0]   sr_r, sr_nxt;
  logic [REG_W-1:0]   oc_r, oc_nxt;
  logic [REG_W-1:0]   orw_r, orw_nxt;
  logic [REG_W-1:0]   hcx_r, hcx_nxt;
  logic [REG_W-1:0]   hcy_r, hcy_nxt;
  logic [COLOR_W-1:0] hcol_r, hcol_nxt;
  logic               active_r, active_nxt;

  logic             is_start;
  logic             live;
  logic             go;
  logic [REG_W-1:0] rad_ext;
  logic             dec_nonneg;
  logic [REG_W-1:0] sr_adv, orw_adv, dec_mid, oc_adv, sc_adv, dec_adv;
  logic             done;

  assign is_start = (inq_type_r == REQ_START);
  assign live     = is_start || active_r;
  // An advance with no circle running is consumed without a run.
  assign go       = inq_vld_r && (run_ready || !live);
  assign in_ready = !inq_vld_r || go;
  assign run_valid = inq_vld_r && live;

  assign rad_ext    = REG_W'(inq_rad_r);
  assign dec_nonneg = !dec_r[REG_W-1];
  assign sr_adv     = dec_nonneg ? sr_r + REG_W'(2) : sr_r;
  assign orw_adv    = dec_nonneg ? orw_r - REG_W'(1) : orw_r;
  assign dec_mid    = dec_nonneg ? dec_r + sr_adv : dec_r;
  assign oc_adv     = oc_r + REG_W'(1);
  assign sc_adv     = sc_r + REG_W'(2);
  assign dec_adv    = dec_mid + sc_adv;

  always_comb begin
    dec_nxt    = dec_r;
    sc_nxt     = sc_r;
    sr_nxt     = sr_r;
    oc_nxt     = oc_r;
    orw_nxt    = orw_r;
    hcx_nxt    = hcx_r;
    hcy_nxt    = hcy_r;
    hcol_nxt   = hcol_r;
    if (is_start) begin
      hcx_nxt  = inq_cx_r;
      hcy_nxt  = inq_cy_r;
      hcol_nxt = inq_color_r;
      dec_nxt  = REG_W'(1) - rad_ext;
      sc_nxt   = REG_W'(1);
      sr_nxt   = REG_W'(0) - {rad_ext[REG_W-2:0], 1'b0};
      oc_nxt   = '0;
      orw_nxt  = rad_ext;
    end else begin
      dec_nxt  = dec_adv;
      sc_nxt   = sc_adv;
      sr_nxt   = sr_adv;
      oc_nxt   = oc_adv;
      orw_nxt  = orw_adv;
    end
    done       = $signed(oc_nxt) >= $signed(orw_nxt);
    active_nxt = !done;
  end

  assign run.cx     = hcx_nxt;
  assign run.cy     = hcy_nxt;
  assign run.oc     = oc_nxt;
  assign run.orw    = orw_nxt;
  assign run.color  = hcol_nxt;
  assign run.is_adv = !is_start;
  assign run.done   = done;

  always_comb begin
    inq_vld_nxt = inq_vld_r;
    if (in_valid && in_ready) begin
      inq_vld_nxt = 1'b1;
    end else if (go) begin
      inq_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_vld_r <= 1'b0;
    end else begin
      inq_vld_r <= inq_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq_type_r  <= in_req_type;
      inq_cx_r    <= in_center_x;
      inq_cy_r    <= in_center_y;
      inq_rad_r   <= in_radius;
      inq_color_r <= in_pixel_color;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r    <= '0;
      sc_r     <= '0;
      sr_r     <= '0;
      oc_r     <= '0;
      orw_r    <= '0;
      hcx_r    <= '0;
      hcy_r    <= '0;
      hcol_r   <= '0;
      active_r <= 1'b0;
    end else if (go && live) begin
      dec_r    <= dec_nxt;
      sc_r     <= sc_nxt;
      sr_r     <= sr_nxt;
      oc_r     <= oc_nxt;
      orw_r    <= orw_nxt;
      hcx_r    <= hcx_nxt;
      hcy_r    <= hcy_nxt;
      hcol_r   <= hcol_nxt;
      active_r <= active_nxt;
    end
  end

`ifndef SYNTHESIS
  a_idle_adv_no_run: assert property (@(posedge clk) disable iff (!rst_n)
    inq_vld_r && !is_start && !active_r |-> !run_valid && go)
    else $error("advance without a circle produced a run");

  a_zero_radius_idle: assert property (@(posedge clk) disable iff (!rst_n)
    go && is_start && inq_rad_r == '0 |=> !active_r)
    else $error("zero radius circle left the block active");

  a_start_col_zero: assert property (@(posedge clk) disable iff (!rst_n)
    run_valid && is_start |-> run.oc == '0)
    else $error("start run has a nonzero column offset");
`endif

endmodule

/* rtl/core/cor_emit.sv */
// ----------------------------------------------------------------------------
// cor_emit
// Pixel emitter: holds one run and sends its pixels one per cycle while
// out_ready is high, four for a start and eight for an advance.
// ----------------------------------------------------------------------------
module cor_emit
  import cor_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               run_valid,
  output logic               run_ready,
  input  cor_run_t           run,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [REG_W-1:0]   out_pixel_x,
  output logic [REG_W-1:0]   out_pixel_y,
  output logic [COLOR_W-1:0] out_color,
  output logic               out_last_of_run,
  output logic               out_circle_done
);

  localparam logic [REG_W-1:0] CoordMask =
    (COORD_BITS >= REG_W) ? {REG_W{1'b1}} : REG_W'((64'd1 << COORD_BITS) - 64'd1);

  cor_run_t   run_r;
  logic       vld_r, vld_nxt;
  logic [2:0] idx_r, idx_nxt;

  logic             last;
  logic             pop;
  logic [2:0]       slot;
  logic [REG_W-1:0] dx, dy, sx, sy;

  assign last      = run_r.is_adv ? (idx_r == 3'd7) : (idx_r == 3'd3);
  assign pop       = vld_r && out_ready;
  assign run_ready = !vld_r || (pop && last);

  always_comb begin
    vld_nxt = vld_r;
    idx_nxt = idx_r;
    if (run_valid && run_ready) begin
      vld_nxt = 1'b1;
      idx_nxt = '0;
    end else if (pop) begin
      if (last) begin
        vld_nxt = 1'b0;
      end
      idx_nxt = idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (run_valid && run_ready) begin
      run_r <= run;
    end
  end

  assign slot = pix_slot(run_r.is_adv, idx_r);
  assign dx   = slot[2] ? run_r.orw : run_r.oc;
  assign dy   = slot[2] ? run_r.oc : run_r.orw;
  assign sx   = slot[0] ? run_r.cx - dx : run_r.cx + dx;
  assign sy   = slot[1] ? run_r.cy - dy : run_r.cy + dy;

  assign out_valid       = vld_r;
  assign out_pixel_x     = sx & CoordMask;
  assign out_pixel_y     = sy & CoordMask;
  assign out_color       = run_r.color;
  assign out_last_of_run = last;
  assign out_circle_done = last && run_r.done;

`ifndef SYNTHESIS
  a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_circle_done |-> out_last_of_run)
    else $error("circle done flagged on a pixel that is not last");

  a_start_short: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && !run_r.is_adv |-> !idx_r[2])
    else $error("start run ran past four pixels");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && !out_ready |=> vld_r && $stable(idx_r))
    else $error("pixel index moved during a stall");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    pop && last && !run_valid |=> !vld_r)
    else $error("emitter stayed busy after its last pixel");
`endif

endmodule

/* rtl/core/circle_outline_rasterizer.sv */
// ----------------------------------------------------------------------------
// circle_outline_rasterizer
// Midpoint circle outline generator with a one pixel per cycle output while out_ready is high.
// ----------------------------------------------------------------------------
// A start request latches center, radius and color and yields the four axis
// pixels; each advance request runs one midpoint iteration and yields the
// eight symmetric pixels, diagonal pixels included twice. The pixel port
// sends one pixel per cycle while out_ready is high: four per start and
// eight per advance. The iteration is combinational in the step unit and
// registered on hand-off; the next request enters the input register
// while the current run is still being emitted. The last pixel of each
// run carries last_of_run, and circle_done once the column offset reaches
// the row offset. An advance with no circle in progress produces no pixels.
module circle_outline_rasterizer
  import cor_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_req_type,
  input  logic [REG_W-1:0]    in_center_x,
  input  logic [REG_W-1:0]    in_center_y,
  input  logic [RADIUS_W-1:0] in_radius,
  input  logic [COLOR_W-1:0]  in_pixel_color,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [REG_W-1:0]    out_pixel_x,
  output logic [REG_W-1:0]    out_pixel_y,
  output logic [COLOR_W-1:0]  out_color,
  output logic                out_last_of_run,
  output logic                out_circle_done
);

  logic     run_valid;
  logic     run_ready;
  cor_run_t run;

  cor_step u_step (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_radius      (in_radius),
    .in_pixel_color (in_pixel_color),
    .run_valid      (run_valid),
    .run_ready      (run_ready),
    .run            (run)
  );

  cor_emit #(
    .COORD_BITS (COORD_BITS)
  ) u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .run_valid       (run_valid),
    .run_ready       (run_ready),
    .run             (run),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_color       (out_color),
    .out_last_of_run (out_last_of_run),
    .out_circle_done (out_circle_done)
  );

endmodule
